// File: design/utf8_to_utf16_decoder_core_defines.svh
// Assertion macros shared by the UTF-8 transcoder RTL.
`ifndef UTF8_TO_UTF16_DECODER_CORE_DEFINES_SVH
`define UTF8_TO_UTF16_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define U8U16_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/u8u16_pkg.sv
// Types and constants shared by the UTF-8 to UTF-16/32 transcoder.
`timescale 1ns / 1ps
`default_nettype none

package u8u16_pkg;

    localparam int CODE_W = 21;

    // Byte classification masks and patterns
    localparam logic [7:0] ASCII_LIMIT  = 8'h80;
    localparam logic [7:0] MASK_LEAD2   = 8'hE0;
    localparam logic [7:0] PAT_LEAD2    = 8'hC0;
    localparam logic [7:0] MASK_LEAD3   = 8'hF0;
    localparam logic [7:0] PAT_LEAD3    = 8'hE0;
    localparam logic [7:0] MASK_LEAD4   = 8'hF8;
    localparam logic [7:0] PAT_LEAD4    = 8'hF0;
    localparam logic [7:0] MASK_CONT    = 8'hC0;
    localparam logic [7:0] PAT_CONT     = 8'h80;

    // Codepoint limits
    localparam logic [CODE_W-1:0] CP_MAX       = 21'h10FFFF;
    localparam logic [CODE_W-1:0] SURR_LO      = 21'h00D800;
    localparam logic [CODE_W-1:0] SURR_HI      = 21'h00DFFF;
    localparam logic [CODE_W-1:0] LOW_SURR     = 21'h00DC00;
    localparam logic [CODE_W-1:0] SUPP_BASE    = 21'h010000;
    localparam logic [CODE_W-1:0] MIN_LEN2     = 21'h000080;
    localparam logic [CODE_W-1:0] MIN_LEN3     = 21'h000800;

    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    typedef struct packed {
        logic [CODE_W-1:0] code_unit;
        logic              is_error;
        logic              string_end;
    } t_result;

    typedef struct packed {
        logic [CODE_W-1:0] partial_code;
        logic [1:0]        bytes_pending;
        logic [2:0]        sequence_length;
        logic              string_failed;
    } t_seq_state;

    typedef struct packed {
        t_seq_state next_state;
        logic [1:0] n_results;
        t_result    res0;
        t_result    res1;
    } t_dec_out;

endpackage

`default_nettype wire

// File: design/u8u16_decode.sv
// Combinational step of the UTF-8 decoder: one byte against the running sequence state.
`timescale 1ns / 1ps
`default_nettype none

module u8u16_decode (
    input  wire logic [7:0]          i_byte,
    input  wire logic                i_eos,
    input  wire logic                i_wide,
    input  wire u8u16_pkg::t_seq_state i_state,
    output u8u16_pkg::t_dec_out      o_dec
);

    logic [u8u16_pkg::CODE_W-1:0] w_acc;
    logic [1:0]                   w_pend_dec;
    logic [u8u16_pkg::CODE_W-1:0] w_lower;
    logic [u8u16_pkg::CODE_W-1:0] w_cp;
    logic [u8u16_pkg::CODE_W-1:0] w_off;
    logic                         w_do_emit;
    logic                         w_do_error;
    logic                         w_lead;
    logic [2:0]                   w_lead_len;
    logic [u8u16_pkg::CODE_W-1:0] w_lead_bits;
    u8u16_pkg::t_seq_state        w_cleared;

    assign w_acc      = {i_state.partial_code[u8u16_pkg::CODE_W-7:0], i_byte[5:0]};
    assign w_pend_dec = i_state.bytes_pending - 2'd1;
    // a single byte is emitted only between sequences, otherwise the gathered codepoint
    assign w_cp       = (i_state.bytes_pending == 2'd0) ? {13'd0, i_byte} : w_acc;
    assign w_off      = w_cp - u8u16_pkg::SUPP_BASE;

    always_comb begin
        w_lead      = 1'b1;
        w_lead_len  = u8u16_pkg::SEQ_LEN2;
        w_lead_bits = {16'd0, i_byte[4:0]};
        if ((i_byte & u8u16_pkg::MASK_LEAD2) == u8u16_pkg::PAT_LEAD2) begin
            w_lead_len  = u8u16_pkg::SEQ_LEN2;
            w_lead_bits = {16'd0, i_byte[4:0]};
        end else if ((i_byte & u8u16_pkg::MASK_LEAD3) == u8u16_pkg::PAT_LEAD3) begin
            w_lead_len  = u8u16_pkg::SEQ_LEN3;
            w_lead_bits = {17'd0, i_byte[3:0]};
        end else if ((i_byte & u8u16_pkg::MASK_LEAD4) == u8u16_pkg::PAT_LEAD4) begin
            w_lead_len  = u8u16_pkg::SEQ_LEN4;
            w_lead_bits = {18'd0, i_byte[2:0]};
        end else begin
            w_lead = 1'b0;
        end
    end

    always_comb begin
        case (i_state.sequence_length)
            u8u16_pkg::SEQ_LEN2: w_lower = u8u16_pkg::MIN_LEN2;
            u8u16_pkg::SEQ_LEN3: w_lower = u8u16_pkg::MIN_LEN3;
            default:             w_lower = u8u16_pkg::SUPP_BASE;
        endcase
    end

    always_comb begin
        w_cleared                 = i_state;
        w_cleared.partial_code    = '0;
        w_cleared.bytes_pending   = '0;
        w_cleared.sequence_length = '0;
    end

    always_comb begin
        o_dec.next_state = i_state;
        w_do_emit        = 1'b0;
        w_do_error       = 1'b0;

        if (i_state.string_failed) begin
            // drop bytes until the string ends
            if (i_eos) begin
                o_dec.next_state.string_failed = 1'b0;
            end
        end else if (i_state.bytes_pending == 2'd0) begin
            if (i_byte < u8u16_pkg::ASCII_LIMIT) begin
                w_do_emit = 1'b1;
            end else if (w_lead) begin
                o_dec.next_state.partial_code    = w_lead_bits;
                o_dec.next_state.sequence_length = w_lead_len;
                o_dec.next_state.bytes_pending   = w_lead_len[1:0] - 2'd1;
                w_do_error = i_eos;
            end else begin
                w_do_error = 1'b1;
            end
        end else if ((i_byte & u8u16_pkg::MASK_CONT) != u8u16_pkg::PAT_CONT) begin
            w_do_error = 1'b1;
        end else if (w_pend_dec != 2'd0) begin
            o_dec.next_state.partial_code  = w_acc;
            o_dec.next_state.bytes_pending = w_pend_dec;
            w_do_error = i_eos;
        end else begin
            if (w_acc < w_lower || w_acc > u8u16_pkg::CP_MAX ||
                (w_acc >= u8u16_pkg::SURR_LO && w_acc <= u8u16_pkg::SURR_HI)) begin
                w_do_error = 1'b1;
            end else begin
                w_do_emit = 1'b1;
            end
        end

        o_dec.n_results = 2'd0;
        o_dec.res0      = '0;
        o_dec.res1      = '0;

        if (w_do_error) begin
            o_dec.next_state               = w_cleared;
            o_dec.next_state.string_failed = ~i_eos;
            o_dec.n_results                = 2'd1;
            o_dec.res0.is_error            = 1'b1;
            o_dec.res0.string_end          = 1'b1;
        end else if (w_do_emit) begin
            o_dec.next_state = w_cleared;
            if (!i_wide && w_cp >= u8u16_pkg::SUPP_BASE) begin
                // split into a surrogate pair, end mark on the low half only
                o_dec.n_results        = 2'd2;
                o_dec.res0.code_unit   = u8u16_pkg::SURR_LO + {11'd0, w_off[19:10]};
                o_dec.res1.code_unit   = u8u16_pkg::LOW_SURR + {11'd0, w_off[9:0]};
                o_dec.res1.string_end  = i_eos;
            end else begin
                o_dec.n_results       = 2'd1;
                o_dec.res0.code_unit  = w_cp;
                o_dec.res0.string_end = i_eos;
            end
        end
    end

endmodule

`default_nettype wire

// File: design/u8u16_result_fifo.sv
// Small result queue: takes up to two results a cycle, hands out one while i_ready is high.
`timescale 1ns / 1ps
`default_nettype none

module u8u16_result_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [1:0]        i_push_n,
    input  wire u8u16_pkg::t_result i_res0,
    input  wire u8u16_pkg::t_result i_res1,
    output logic                   o_room2,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output u8u16_pkg::t_result     o_res
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    u8u16_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;
    logic [PTR_W-1:0]   w_wr_next;
    logic               w_pop;

    assign w_pop     = o_valid & i_ready;
    assign w_wr_next = r_wr_ptr + PTR_W'(1);
    assign o_valid   = (r_count != '0);
    assign o_res     = r_mem[r_rd_ptr];
    assign o_room2   = (r_count <= CNT_W'(DEPTH - 2));

    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_W'(i_push_n);
        n_rd_ptr = r_rd_ptr + PTR_W'(w_pop);
        n_count  = r_count + CNT_W'(i_push_n) - CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[w_wr_next] <= i_res1;
        end
    end

endmodule

`default_nettype wire

// File: design/utf8_to_utf16_decoder_core.sv
// Top level of the streaming UTF-8 to UTF-16/UTF-32 transcoder.
// Path: a byte accepted into the input register is decoded combinationally and its results
//   are written into the result queue, whose head drives the master side.
// Throughput: one byte per cycle; a surrogate pair ends a four-byte sequence, so output
//   keeps up. Input stalls only while the result queue has fewer than two free entries.
// Reset (synchronous, active low) clears sequence state, wide mode and the result queue.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_to_utf16_decoder_core_defines.svh"

module utf8_to_utf16_decoder_core #(
    parameter int OUT_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // stream in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic        s_axis_tlast,   // end_of_string
    // stream out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [20:0] code_unit, [23:21] zero
    output logic             m_axis_tuser,   // is_error
    output logic             m_axis_tlast,   // string_end
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic                  r_wide;
    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_eos;
    u8u16_pkg::t_seq_state r_seq;
    u8u16_pkg::t_dec_out   w_dec;
    u8u16_pkg::t_result    w_head;
    logic                  w_room2;
    logic                  w_advance;
    logic [1:0]            w_push_n;

    assign pready = 1'b1;
    assign prdata = {31'd0, r_wide};

    assign w_advance     = r_in_valid & w_room2;
    assign s_axis_tready = ~r_in_valid | w_room2;
    assign w_push_n      = w_advance ? w_dec.n_results : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
            r_wide <= pwdata[0];
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_eos  <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= '0;
        end else if (w_advance) begin
            r_seq <= w_dec.next_state;
        end
    end

    u8u16_decode u_decode (
        .i_byte  (r_in_byte),
        .i_eos   (r_in_eos),
        .i_wide  (r_wide),
        .i_state (r_seq),
        .o_dec   (w_dec)
    );

    u8u16_result_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_result_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (w_push_n),
        .i_res0   (w_dec.res0),
        .i_res1   (w_dec.res1),
        .o_room2  (w_room2),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_res    (w_head)
    );

    assign m_axis_tdata = {3'd0, w_head.code_unit};
    assign m_axis_tuser = w_head.is_error;
    assign m_axis_tlast = w_head.string_end;

    `U8U16_ASSERT_NOW(a_pair_only_narrow, i_clk, i_rst_n,
        w_advance && w_dec.n_results == 2'd2, !r_wide, "surrogate pair in wide mode")
    `U8U16_ASSERT_NOW(a_error_code_zero, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser, m_axis_tdata == 24'd0 && m_axis_tlast,
        "error result with nonzero code or no end mark")
    `U8U16_ASSERT_NOW(a_failed_idle_seq, i_clk, i_rst_n,
        r_seq.string_failed, r_seq.bytes_pending == 2'd0 && r_seq.sequence_length == 3'd0,
        "failed string still holds a partial sequence")
    `U8U16_ASSERT_NEXT(a_eos_clears_seq, i_clk, i_rst_n,
        w_advance && r_in_eos, r_seq.bytes_pending == 2'd0 && !r_seq.string_failed,
        "string end left sequence state behind")

endmodule

`default_nettype wire
